/* rtl/core/apc_pkg.sv */
// Shared types, constants and arithmetic helpers for the ARGB pixel compositor.
package apc_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned PIX_W     = CH_W * NUM_LANES;
    localparam int unsigned ALPHA_LANE = NUM_LANES - 1;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    localparam logic [CH_W-1:0] CH_MAX       = 8'hff;
    localparam logic [15:0]     ROUND_HALF   = 16'd127;
    localparam logic            REG_IDX_MODE = 1'b0;
    localparam logic            REG_IDX_GA   = 1'b1;

    typedef enum logic [1:0] {
        MODE_COPY      = 2'd0,
        MODE_CROSSFADE = 2'd1,
        MODE_OVER      = 2'd2,
        MODE_PREMUL    = 2'd3
    } mode_t;

    // Scale factors for one pixel, handed from the factor stage to the lanes
    typedef struct packed {
        logic [CH_W-1:0] col_fac;    // source colour channels
        logic [CH_W-1:0] alpha_fac;  // source alpha channel
        logic [CH_W-1:0] dst_fac;    // all destination channels
    } fac_t;

    // Round(v*f/255) for 8-bit operands, division by 255 done as add and shift
    function automatic logic [CH_W-1:0] mul_div255(input logic [CH_W-1:0] v,
                                                   input logic [CH_W-1:0] f);
        logic [15:0] x;
        logic [15:0] q;
        begin
            x = ({8'd0, v} * {8'd0, f}) + ROUND_HALF;
            q = x + {8'd0, x[15:8]} + 16'd1;
            mul_div255 = q[15:8];
        end
    endfunction

endpackage

/* rtl/core/apc_factor.sv */
// Factor stage: scaled source alpha and per-mode scale factors.
module apc_factor (
    input  logic [apc_pkg::CH_W-1:0] src_alpha,
    input  logic [apc_pkg::CH_W-1:0] opacity,
    input  apc_pkg::mode_t           mode,
    output apc_pkg::fac_t            fac
);
    import apc_pkg::*;

    logic [CH_W-1:0] sa;

    // Scale source alpha by the global alpha
    assign sa = mul_div255(src_alpha, opacity);

    // Select factors per blend mode
    always_comb begin
        fac.alpha_fac = opacity;
        case (mode)
            MODE_CROSSFADE: begin
                fac.col_fac = opacity;
                fac.dst_fac = ~opacity;
            end
            MODE_OVER: begin
                fac.col_fac = sa;
                fac.dst_fac = ~sa;
            end
            MODE_PREMUL: begin
                fac.col_fac = opacity;
                fac.dst_fac = ~sa;
            end
            default: begin
                fac.col_fac = opacity;
                fac.dst_fac = ~opacity;
            end
        endcase
    end

endmodule

/* rtl/core/apc_lane.sv */
// One channel lane: scale source and destination, add, saturate.
module apc_lane (
    input  logic [apc_pkg::CH_W-1:0] src_ch,
    input  logic [apc_pkg::CH_W-1:0] dst_ch,
    input  logic [apc_pkg::CH_W-1:0] src_fac,
    input  logic [apc_pkg::CH_W-1:0] dst_fac,
    output logic [apc_pkg::CH_W-1:0] mix_ch
);
    import apc_pkg::*;

    logic [CH_W-1:0] s_term;
    logic [CH_W-1:0] d_term;
    logic [CH_W:0]   sum;

    assign s_term = mul_div255(src_ch, src_fac);
    assign d_term = mul_div255(dst_ch, dst_fac);
    assign sum    = {1'b0, s_term} + {1'b0, d_term};

    // Saturate at full scale
    assign mix_ch = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];

endmodule

/* rtl/core/argb_pixel_compositor.sv */
// Top level: APB registers, factor stage, four channel lanes and merge stage.
// A request passes through the stage 1, stage 2 and output registers to the result.
// Throughput: one pixel per cycle while m_ready does not hold the output.
// Each stage holds under backpressure and takes a new request once its successor frees.
// Reset (aresetn low, synchronous): pipeline emptied, blend mode = copy,
// global opacity = 255.
module argb_pixel_compositor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [apc_pkg::PIX_W-1:0]     s_source_pixel,
    input  logic [apc_pkg::PIX_W-1:0]     s_destination_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [apc_pkg::PIX_W-1:0]     m_result_pixel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apc_pkg::APB_AW-1:0]    paddr,
    input  logic [apc_pkg::APB_DW-1:0]    pwdata,
    output logic [apc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import apc_pkg::*;

    mode_t           blend_mode_reg;
    logic [CH_W-1:0] opacity_reg;

    logic            p1_valid_reg;
    logic [PIX_W-1:0] p1_src_reg;
    logic [PIX_W-1:0] p1_dst_reg;
    fac_t            p1_fac_reg;
    fac_t            fac_next;

    logic            p2_valid_reg;
    logic [PIX_W-1:0] p2_src_reg;
    logic [PIX_W-1:0] p2_mix_reg;
    logic [PIX_W-1:0] mix_next;

    logic            out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic [PIX_W-1:0] out_pixel_next;

    logic            out_ready;
    logic            p2_ready;
    logic            p1_ready;
    logic            cfg_wr;

    // Register write and readback
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_mode_reg <= MODE_COPY;
            opacity_reg    <= CH_MAX;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IDX_MODE) begin
                blend_mode_reg <= mode_t'(pwdata[1:0]);
            end else begin
                opacity_reg <= pwdata[CH_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_GA) begin
            prdata[CH_W-1:0] = opacity_reg;
        end else begin
            prdata[1:0] = blend_mode_reg;
        end
    end

    // Per-stage ready: a stage takes a request when empty or when it moves on
    assign out_ready = !out_valid_reg || m_ready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign s_ready   = p1_ready;

    // Stage 1: factors
    apc_factor u_factor (
        .src_alpha (s_source_pixel[PIX_W-1 -: CH_W]),
        .opacity   (opacity_reg),
        .mode      (blend_mode_reg),
        .fac       (fac_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready && s_valid) begin
            p1_src_reg <= s_source_pixel;
            p1_dst_reg <= s_destination_pixel;
            p1_fac_reg <= fac_next;
        end
    end

    // Stage 2: channel lanes side by side
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        apc_lane u_lane (
            .src_ch  (p1_src_reg[i*CH_W +: CH_W]),
            .dst_ch  (p1_dst_reg[i*CH_W +: CH_W]),
            .src_fac ((i == ALPHA_LANE) ? p1_fac_reg.alpha_fac : p1_fac_reg.col_fac),
            .dst_fac (p1_fac_reg.dst_fac),
            .mix_ch  (mix_next[i*CH_W +: CH_W])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_ready) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_ready && p1_valid_reg) begin
            p2_src_reg <= p1_src_reg;
            p2_mix_reg <= mix_next;
        end
    end

    // Stage 3: merge lanes, copy mode passes the source through
    always_comb begin
        case (blend_mode_reg)
            MODE_COPY: out_pixel_next = p2_src_reg;
            default:   out_pixel_next = p2_mix_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p2_valid_reg) begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_pixel = out_pixel_reg;

endmodule
